### sv/mau_pkg.sv
package mau_pkg;

  localparam int WORD_BITS = 64;
  localparam int RES_W     = 59;
  localparam int HALF_W    = 32;
  localparam int PROD_W    = 2 * RES_W;
  localparam int CFG_IDX_W = 2;

  // barrett shift offsets around the modulus bit length
  localparam int BAR_PRE_SHIFT  = 2;
  localparam int BAR_POST_SHIFT = 5;
  localparam int BITS_MIN       = 2;
  localparam int BITS_MAX       = 59;
  localparam int MOD_RESET      = 2;

  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_SUB     = 2'd1;
  localparam logic [1:0] FUNC_BARRETT = 2'd2;
  localparam logic [1:0] FUNC_SHOUP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR  = 2'd2;

  typedef struct packed {
    logic [RES_W-1:0]     modulus;
    logic [5:0]           sh_lo;
    logic [6:0]           sh_hi;
    logic [WORD_BITS-1:0] factor;
  } mau_cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] func;
  } mau_ctl_t;

  typedef struct packed {
    logic [PROD_W-1:0]    prod;
    logic [RES_W-1:0]     qs;
    logic [WORD_BITS-1:0] addsub;
  } mau_front_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] q;
    logic [WORD_BITS-1:0] base;
  } mau_quot_t;

endpackage

### sv/mau_mul_front.sv
module mau_mul_front
  import mau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  mau_cfg_t             cfg,
  input  mau_ctl_t             in_ctl,
  output logic                 in_ready,
  input  logic [RES_W-1:0]     in_a,
  input  logic [RES_W-1:0]     in_b,
  input  logic [WORD_BITS-1:0] in_sf,
  output mau_ctl_t             out_ctl,
  output mau_front_t           out_data,
  input  logic                 out_ready
);

  localparam int NS    = 2;
  localparam int RH_W  = RES_W - HALF_W;
  localparam int FH_W  = WORD_BITS - HALF_W;
  localparam int LL_W  = 2 * HALF_W;
  localparam int LH_W  = HALF_W + RH_W;
  localparam int HH_W  = 2 * RH_W;
  localparam int LF_W  = HALF_W + FH_W;
  localparam int HF_W  = RH_W + FH_W;
  localparam int HLF_W = RH_W + HALF_W;
  localparam int AS_W  = RES_W + WORD_BITS;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  // stage 1: partial products and add/subtract
  logic [HALF_W-1:0]    a_lo, b_lo, sf_lo;
  logic [RH_W-1:0]      a_hi, b_hi;
  logic [FH_W-1:0]      sf_hi;
  logic [LL_W-1:0]      ab_ll_nxt, ab_ll_r;
  logic [LH_W-1:0]      ab_lh_nxt, ab_lh_r, ab_hl_nxt, ab_hl_r;
  logic [HH_W-1:0]      ab_hh_nxt, ab_hh_r;
  logic [LL_W-1:0]      as_ll_nxt, as_ll_r;
  logic [LF_W-1:0]      as_lh_nxt, as_lh_r;
  logic [HLF_W-1:0]     as_hl_nxt, as_hl_r;
  logic [HF_W-1:0]      as_hh_nxt, as_hh_r;
  logic [WORD_BITS-1:0] sum_w, dif_w, addsub1_nxt, addsub1_r;
  logic [1:0]           func1_r;

  // stage 2: summed products
  logic [LH_W:0]        ab_mid;
  logic [LF_W:0]        as_mid;
  logic [AS_W-1:0]      as_sum;
  logic [PROD_W-1:0]    prod_nxt, prod_r;
  logic [RES_W-1:0]     qs_nxt, qs_r;
  logic [WORD_BITS-1:0] addsub2_r;
  logic [1:0]           func2_r;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  assign a_lo  = in_a[HALF_W-1:0];
  assign a_hi  = in_a[RES_W-1:HALF_W];
  assign b_lo  = in_b[HALF_W-1:0];
  assign b_hi  = in_b[RES_W-1:HALF_W];
  assign sf_lo = in_sf[HALF_W-1:0];
  assign sf_hi = in_sf[WORD_BITS-1:HALF_W];

  assign ab_ll_nxt = LL_W'(a_lo) * LL_W'(b_lo);
  assign ab_lh_nxt = LH_W'(a_lo) * LH_W'(b_hi);
  assign ab_hl_nxt = LH_W'(a_hi) * LH_W'(b_lo);
  assign ab_hh_nxt = HH_W'(a_hi) * HH_W'(b_hi);
  assign as_ll_nxt = LL_W'(a_lo) * LL_W'(sf_lo);
  assign as_lh_nxt = LF_W'(a_lo) * LF_W'(sf_hi);
  assign as_hl_nxt = HLF_W'(a_hi) * HLF_W'(sf_lo);
  assign as_hh_nxt = HF_W'(a_hi) * HF_W'(sf_hi);

  // subtract wraps through the modulus when b is the larger
  always_comb begin
    sum_w = WORD_BITS'(in_a) + WORD_BITS'(in_b);
    if (in_a >= in_b) begin
      dif_w = WORD_BITS'(in_a) - WORD_BITS'(in_b);
    end else begin
      dif_w = WORD_BITS'(cfg.modulus) + WORD_BITS'(in_a) - WORD_BITS'(in_b);
    end
    addsub1_nxt = (in_ctl.func == FUNC_ADD) ? sum_w : dif_w;
  end

  always_comb begin
    ab_mid   = (LH_W+1)'(ab_lh_r) + (LH_W+1)'(ab_hl_r);
    prod_nxt = PROD_W'(ab_ll_r) + (PROD_W'(ab_mid) << HALF_W)
             + (PROD_W'(ab_hh_r) << (2 * HALF_W));
    as_mid   = (LF_W+1)'(as_lh_r) + (LF_W+1)'(as_hl_r);
    as_sum   = AS_W'(as_ll_r) + (AS_W'(as_mid) << HALF_W)
             + (AS_W'(as_hh_r) << (2 * HALF_W));
    qs_nxt   = as_sum[WORD_BITS +: RES_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ctl.valid;
      end
      if (rdy[1]) begin
        v_r[1] <= v_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ab_ll_r   <= ab_ll_nxt;
      ab_lh_r   <= ab_lh_nxt;
      ab_hl_r   <= ab_hl_nxt;
      ab_hh_r   <= ab_hh_nxt;
      as_ll_r   <= as_ll_nxt;
      as_lh_r   <= as_lh_nxt;
      as_hl_r   <= as_hl_nxt;
      as_hh_r   <= as_hh_nxt;
      addsub1_r <= addsub1_nxt;
      func1_r   <= in_ctl.func;
    end
    if (rdy[1]) begin
      prod_r    <= prod_nxt;
      qs_r      <= qs_nxt;
      addsub2_r <= addsub1_r;
      func2_r   <= func1_r;
    end
  end

  assign out_ctl.valid   = v_r[NS-1];
  assign out_ctl.func    = func2_r;
  assign out_data.prod   = prod_r;
  assign out_data.qs     = qs_r;
  assign out_data.addsub = addsub2_r;

endmodule

### sv/mau_barrett_q.sv
module mau_barrett_q
  import mau_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mau_cfg_t   cfg,
  input  mau_ctl_t   in_ctl,
  output logic       in_ready,
  input  mau_front_t in_data,
  output mau_ctl_t   out_ctl,
  output mau_quot_t  out_data,
  input  logic       out_ready
);

  localparam int NS   = 5;
  localparam int LL_W = 2 * HALF_W;
  localparam int TH_W = PROD_W - 3 * HALF_W;
  localparam int TT_W = 2 * LL_W;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;
  logic [1:0]    func_r [NS];
  logic [WORD_BITS-1:0] base_r [NS];
  logic [RES_W-1:0]     qs_r [NS];

  logic [WORD_BITS-1:0] base_nxt;

  // stage 3: pre-shift of the full product
  logic [PROD_W-1:0] t_nxt, t_r;

  // stage 4: t times factor, products above bit 127 dropped
  logic [HALF_W-1:0] t0, t1, t2, f0, f1;
  logic [TH_W-1:0]   t3;
  logic [LL_W-1:0]   p00_nxt, p01_nxt, p10_nxt, p11_nxt, p20_nxt;
  logic [LL_W-1:0]   p00_r, p01_r, p10_r, p11_r, p20_r;
  logic [HALF_W-1:0] p21_nxt, p30_nxt, p21_r, p30_r;

  // stage 5: column sums
  logic [LL_W:0]     s32_nxt, s32_r;
  logic [LL_W-1:0]   s64_nxt, s64_r, p00b_r;
  logic [HALF_W-1:0] s96_nxt, s96_r;

  // stage 6: full 128-bit wrapped product
  logic [TT_W-1:0] tt_nxt, tt_r;

  // stage 7: quotient estimate
  logic [TT_W-1:0]      tt_sh;
  logic [WORD_BITS-1:0] q_nxt, q_r;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  // add and subtract carry their finished value, the multiplies the low product word
  assign base_nxt = (in_ctl.func == FUNC_ADD || in_ctl.func == FUNC_SUB) ?
                    in_data.addsub : in_data.prod[WORD_BITS-1:0];
  assign t_nxt    = in_data.prod >> cfg.sh_lo;

  assign t0 = t_r[HALF_W-1:0];
  assign t1 = t_r[2*HALF_W-1:HALF_W];
  assign t2 = t_r[3*HALF_W-1:2*HALF_W];
  assign t3 = t_r[PROD_W-1:3*HALF_W];
  assign f0 = cfg.factor[HALF_W-1:0];
  assign f1 = cfg.factor[WORD_BITS-1:HALF_W];

  assign p00_nxt = LL_W'(t0) * LL_W'(f0);
  assign p01_nxt = LL_W'(t0) * LL_W'(f1);
  assign p10_nxt = LL_W'(t1) * LL_W'(f0);
  assign p11_nxt = LL_W'(t1) * LL_W'(f1);
  assign p20_nxt = LL_W'(t2) * LL_W'(f0);
  assign p21_nxt = t2 * f1;
  assign p30_nxt = HALF_W'(t3) * f0;

  assign s32_nxt = (LL_W+1)'(p01_r) + (LL_W+1)'(p10_r);
  assign s64_nxt = p11_r + p20_r;
  assign s96_nxt = p21_r + p30_r;

  assign tt_nxt = TT_W'(p00b_r) + (TT_W'(s32_r) << HALF_W)
                + (TT_W'(s64_r) << (2 * HALF_W)) + (TT_W'(s96_r) << (3 * HALF_W));

  assign tt_sh = tt_r >> cfg.sh_hi;
  assign q_nxt = (func_r[3] == FUNC_SHOUP) ? WORD_BITS'(qs_r[3]) : tt_sh[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ctl.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      func_r[0] <= in_ctl.func;
      base_r[0] <= base_nxt;
      qs_r[0]   <= in_data.qs;
      t_r       <= t_nxt;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        func_r[k] <= func_r[k-1];
        base_r[k] <= base_r[k-1];
        qs_r[k]   <= qs_r[k-1];
      end
    end
    if (rdy[1]) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      p20_r <= p20_nxt;
      p21_r <= p21_nxt;
      p30_r <= p30_nxt;
    end
    if (rdy[2]) begin
      s32_r  <= s32_nxt;
      s64_r  <= s64_nxt;
      s96_r  <= s96_nxt;
      p00b_r <= p00_r;
    end
    if (rdy[3]) begin
      tt_r <= tt_nxt;
    end
    if (rdy[4]) begin
      q_r <= q_nxt;
    end
  end

  assign out_ctl.valid = v_r[NS-1];
  assign out_ctl.func  = func_r[NS-1];
  assign out_data.q    = q_r;
  assign out_data.base = base_r[NS-1];

endmodule

### sv/mau_reduce.sv
module mau_reduce
  import mau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mau_cfg_t         cfg,
  input  mau_ctl_t         in_ctl,
  output logic             in_ready,
  input  mau_quot_t        in_data,
  output mau_ctl_t         out_ctl,
  output logic [RES_W-1:0] out_res,
  input  logic             out_ready
);

  localparam int NS   = 4;
  localparam int LL_W = 2 * HALF_W;
  localparam int MH_W = RES_W - HALF_W;
  localparam int LH_W = HALF_W + MH_W;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;
  logic [1:0]    func_r [NS];

  logic [HALF_W-1:0]    ql, qh, ml;
  logic [MH_W-1:0]      mh;
  logic [WORD_BITS-1:0] m_w;

  // stage 8: q times modulus, low word only
  logic [LL_W-1:0]      r_ll_nxt, r_ll_r, r_hl_nxt, r_hl_r;
  logic [LH_W-1:0]      r_lh_nxt, r_lh_r;
  logic [WORD_BITS-1:0] base8_r;

  // stage 9: remainder
  logic [WORD_BITS-1:0] qm;
  logic [WORD_BITS-1:0] res9_nxt, res9_r;

  // stages 10 and 11: corrections
  logic [WORD_BITS-1:0] res10_nxt, res10_r, res11_w;
  logic [RES_W-1:0]     res11_nxt, res11_r;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  assign ql  = in_data.q[HALF_W-1:0];
  assign qh  = in_data.q[WORD_BITS-1:HALF_W];
  assign ml  = cfg.modulus[HALF_W-1:0];
  assign mh  = cfg.modulus[RES_W-1:HALF_W];
  assign m_w = WORD_BITS'(cfg.modulus);

  assign r_ll_nxt = LL_W'(ql) * LL_W'(ml);
  assign r_lh_nxt = LH_W'(ql) * LH_W'(mh);
  assign r_hl_nxt = LL_W'(qh) * LL_W'(ml);

  always_comb begin
    qm = r_ll_r + ((WORD_BITS'(r_lh_r) + r_hl_r) << HALF_W);
    if (func_r[0] == FUNC_BARRETT || func_r[0] == FUNC_SHOUP) begin
      res9_nxt = base8_r - qm;
    end else begin
      res9_nxt = base8_r;
    end
  end

  // subtract is already reduced; barrett gets a second pass
  always_comb begin
    if (func_r[1] != FUNC_SUB && res9_r >= m_w) begin
      res10_nxt = res9_r - m_w;
    end else begin
      res10_nxt = res9_r;
    end
    if (func_r[2] == FUNC_BARRETT && res10_r >= m_w) begin
      res11_w = res10_r - m_w;
    end else begin
      res11_w = res10_r;
    end
    res11_nxt = res11_w[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_ctl.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      func_r[0] <= in_ctl.func;
      r_ll_r    <= r_ll_nxt;
      r_lh_r    <= r_lh_nxt;
      r_hl_r    <= r_hl_nxt;
      base8_r   <= in_data.base;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        func_r[k] <= func_r[k-1];
      end
    end
    if (rdy[1]) begin
      res9_r <= res9_nxt;
    end
    if (rdy[2]) begin
      res10_r <= res10_nxt;
    end
    if (rdy[3]) begin
      res11_r <= res11_nxt;
    end
  end

  assign out_ctl.valid = v_r[NS-1];
  assign out_ctl.func  = func_r[NS-1];
  assign out_res       = res11_r;

endmodule

### sv/modular_arithmetic_unit.sv
// channel   direction  handshake             beat
// in_       in         in_valid / in_stall   in_func, in_operand_a, in_operand_b,
//                                            in_shoup_factor
// out_      out        out_valid / out_stall out_result
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat per cycle in and out while out_stall is low; the pipeline depth is
// set by the three chained multiplies (a*b, t*factor, q*modulus), each cut into
// 32-bit partial products with a register stage before its summing stage.
// rst_n clears every stage's valid bit and loads the configuration reset values.
// a stall holds only the stages that are full, so bubbles still close up and
// in_stall rises only when every stage holds a beat and out_stall is high.
module modular_arithmetic_unit
  import mau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  input  logic [RES_W-1:0]     in_operand_a,
  input  logic [RES_W-1:0]     in_operand_b,
  input  logic [WORD_BITS-1:0] in_shoup_factor,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RES_W-1:0]     out_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  logic [RES_W-1:0]     modulus_r;
  logic [5:0]           sh_lo_r, sh_lo_nxt;
  logic [6:0]           sh_hi_r, sh_hi_nxt;
  logic [WORD_BITS-1:0] factor_r;
  logic [5:0]           bits_clamp;
  logic                 cfg_wr;
  mau_cfg_t             cfg;

  mau_ctl_t   in_ctl, front_ctl, quot_ctl, red_ctl;
  mau_front_t front_data;
  mau_quot_t  quot_data;
  logic       front_ready, quot_ready, red_ready;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // bit length is clamped once at write, and stored as the two barrett shifts
  always_comb begin
    if (cfg_data[5:0] < 6'(BITS_MIN)) begin
      bits_clamp = 6'(BITS_MIN);
    end else if (cfg_data[5:0] > 6'(BITS_MAX)) begin
      bits_clamp = 6'(BITS_MAX);
    end else begin
      bits_clamp = cfg_data[5:0];
    end
    sh_lo_nxt = bits_clamp - 6'(BAR_PRE_SHIFT);
    sh_hi_nxt = 7'(bits_clamp) + 7'(BAR_POST_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= RES_W'(MOD_RESET);
      sh_lo_r   <= 6'(BITS_MIN - BAR_PRE_SHIFT);
      sh_hi_r   <= 7'(BITS_MIN + BAR_POST_SHIFT);
      factor_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MODULUS: begin
          modulus_r <= cfg_data[RES_W-1:0];
        end
        CFG_BITS: begin
          sh_lo_r <= sh_lo_nxt;
          sh_hi_r <= sh_hi_nxt;
        end
        CFG_FACTOR: begin
          factor_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.modulus = modulus_r;
  assign cfg.sh_lo   = sh_lo_r;
  assign cfg.sh_hi   = sh_hi_r;
  assign cfg.factor  = factor_r;

  assign in_ctl.valid = in_valid;
  assign in_ctl.func  = in_func;

  mau_mul_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ctl    (in_ctl),
    .in_ready  (front_ready),
    .in_a      (in_operand_a),
    .in_b      (in_operand_b),
    .in_sf     (in_shoup_factor),
    .out_ctl   (front_ctl),
    .out_data  (front_data),
    .out_ready (quot_ready)
  );

  mau_barrett_q u_quot (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ctl    (front_ctl),
    .in_ready  (quot_ready),
    .in_data   (front_data),
    .out_ctl   (quot_ctl),
    .out_data  (quot_data),
    .out_ready (red_ready)
  );

  mau_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ctl    (quot_ctl),
    .in_ready  (red_ready),
    .in_data   (quot_data),
    .out_ctl   (red_ctl),
    .out_res   (out_result),
    .out_ready (!out_stall)
  );

  assign in_stall  = !front_ready;
  assign out_valid = red_ctl.valid;

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");

endmodule
